FILE: sv/red_pkg.sv
package red_pkg;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_BASE   = 2'd1;
	localparam logic [1:0] REQ_IMPACT = 2'd2;
	localparam logic [1:0] REQ_PAUSE  = 2'd3;

	localparam logic [2:0] PAD_READY = 3'd6;
	localparam logic [2:0] PAD_LOST  = 3'd4;

	localparam logic [7:0] LEVEL_MAX = 8'hff;

	// quotient of the fade term always fits in 8 bits
	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] pad_state;
		logic [7:0] new_high;
		logic [7:0] new_low;
		logic [7:0] impact_strength;
		logic [7:0] impact_length;
	} req_t;

	typedef struct packed {
		logic       motor_onoff;
		logic [7:0] motor_level;
		logic       pad_active;
		logic       send_setup;
	} rsp_t;

	typedef struct packed {
		logic take;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic need_div;
	} sts_t;

	// bit-reversed frame index; the last entry is pinned to 254
	function automatic logic [7:0] dither_value(input logic [7:0] idx);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = idx[i];
		end
		if (idx == 8'hff) begin
			r = 8'hfe;
		end
		return r;
	endfunction

endpackage

FILE: sv/red_chan_if.sv
interface red_chan_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/red_ctrl.sv
module red_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  red_pkg::sts_t     sts,
	output red_pkg::cmd_t     cmd,
	output logic              in_ready,
	output logic              out_valid
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                state_q;
	logic [red_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.take     = in_valid && (state_q == ST_IDLE);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.load_out = (state_q == ST_FIN) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && sts.is_tick) begin
						cnt_q   <= '0;
						state_q <= sts.need_div ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == red_pkg::CNT_W'(red_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/red_dp.sv
module red_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  red_pkg::req_t  req,
	input  red_pkg::cmd_t  cmd,
	output red_pkg::sts_t  sts,
	output red_pkg::rsp_t  rsp
);

	logic        active_flag_q;
	logic [7:0]  base_high_q;
	logic [7:0]  base_low_q;
	logic [7:0]  jolt_amount_q;
	logic [7:0]  time_left_q;
	logic [7:0]  fade_point_q;
	logic [15:0] frame_count_q;

	logic        setup_q;
	logic [7:0]  dither_q;
	logic [7:0]  rem_q;
	logic [7:0]  quo_q;
	red_pkg::rsp_t rsp_q;

	logic [15:0] prod;
	logic [8:0]  trial;
	logic        trial_ge;
	logic [8:0]  high_sum;
	logic [8:0]  low_sum;

	assign sts.is_tick  = (req.req_type == red_pkg::REQ_TICK);
	assign sts.need_div = (time_left_q != 8'd0) && (time_left_q <= fade_point_q)
		&& (fade_point_q != 8'd0);

	assign prod = {8'd0, jolt_amount_q} * {8'd0, time_left_q};

	// restoring divider, one quotient bit per step
	assign trial    = {rem_q, quo_q[7]};
	assign trial_ge = (trial >= {1'b0, fade_point_q});

	assign high_sum = {1'b0, base_high_q} + {1'b0, quo_q};
	assign low_sum  = {1'b0, base_low_q} + {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_flag_q <= 1'b0;
			base_high_q   <= '0;
			base_low_q    <= '0;
			jolt_amount_q <= '0;
			time_left_q   <= '0;
			fade_point_q  <= '0;
			frame_count_q <= '0;
		end else if (cmd.take) begin
			unique case (req.req_type)
				red_pkg::REQ_BASE: begin
					base_high_q <= req.new_high;
					base_low_q  <= req.new_low;
				end
				red_pkg::REQ_IMPACT: begin
					if (req.impact_strength > jolt_amount_q
							|| req.impact_length > time_left_q) begin
						fade_point_q  <= {1'b0, req.impact_length[7:1]};
						time_left_q   <= req.impact_length;
						jolt_amount_q <= req.impact_strength;
					end
				end
				red_pkg::REQ_PAUSE: begin
					base_high_q <= '0;
					base_low_q  <= '0;
					time_left_q <= '0;
				end
				red_pkg::REQ_TICK: begin
					if (req.pad_state == red_pkg::PAD_READY) begin
						active_flag_q <= 1'b1;
					end else if (req.pad_state < red_pkg::PAD_LOST) begin
						active_flag_q <= 1'b0;
					end
					if (time_left_q != 8'd0) begin
						time_left_q <= time_left_q - 8'd1;
					end else begin
						jolt_amount_q <= '0;
					end
					frame_count_q <= frame_count_q + 16'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// per-tick working registers; quo_q ends up holding the jolt term
	always_ff @(posedge clk) begin
		if (cmd.take && sts.is_tick) begin
			setup_q  <= (req.pad_state == red_pkg::PAD_READY) && !active_flag_q;
			dither_q <= red_pkg::dither_value(frame_count_q[8:1]);
			rem_q    <= prod[15:8];
			if (sts.need_div) begin
				quo_q <= prod[7:0];
			end else if (time_left_q != 8'd0) begin
				quo_q <= jolt_amount_q;
			end else begin
				quo_q <= '0;
			end
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? 8'(trial - {1'b0, fade_point_q}) : trial[7:0];
			quo_q <= {quo_q[6:0], trial_ge};
		end

		if (cmd.load_out) begin
			rsp_q.motor_onoff <= ({1'b0, dither_q} < high_sum);
			rsp_q.motor_level <= low_sum[8] ? red_pkg::LEVEL_MAX : low_sum[7:0];
			rsp_q.pad_active  <= active_flag_q;
			rsp_q.send_setup  <= setup_q;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: sv/rumble_envelope_dither_core.sv
// Rumble pad driver: frame ticks, base-level writes, impacts and pauses come in
// on req; each frame tick gives one result on rsp, the other request types give
// none. Base writes, impacts and pauses are handled in the idle state alone. A
// tick goes straight to its final state when the envelope is idle or at full
// jolt; while it fades, the fade term jolt*time/fade goes through an 8-step
// restoring divider that produces one quotient bit per cycle. The result sits
// in an output register, so non-tick requests keep flowing while it waits; a
// later tick stalls only in its final state until the prior result is taken.
module rumble_envelope_dither_core (
	input logic       clk,
	input logic       arst_n,
	red_chan_if.sink   req,
	red_chan_if.source rsp
);

	red_pkg::cmd_t cmd;
	red_pkg::sts_t sts;
	red_pkg::rsp_t rsp_data;

	red_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (req.ready),
		.out_valid (rsp.valid)
	);

	red_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.data),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp_data)
	);

	assign rsp.data = rsp_data;

	// no new transaction is taken while the divider is stepping
	a_no_take_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !req.ready)
		else $error("request accepted during fade division");

	// a fading tick cannot produce its result in the following cycle
	a_div_delays_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && sts.is_tick && sts.need_div) |=> !cmd.load_out)
		else $error("fade result loaded before division finished");

	// a non-tick request never yields a result
	a_no_result_for_other: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !sts.is_tick) |=> !cmd.load_out)
		else $error("result produced for a non-tick request");

	// the output register is never overwritten while it holds an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("pending result overwritten");

endmodule
